// ===== design/bal_pkg.sv =====
// shared types and constants for the bounded array list engine
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int CMD_W        = 3;
	localparam int POS_W        = 4;
	localparam int WORD_W       = 32;
	localparam int STATUS_W     = 2;
	localparam int FILL_W       = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH      = 3'd0,
		CMD_POP       = 3'd1,
		CMD_REM_ORD   = 3'd2,
		CMD_REM_SWAP  = 3'd3,
		CMD_INS_ORD   = 3'd4,
		CMD_INS_SWAP  = 3'd5,
		CMD_QUERY     = 3'd6
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2,
		STS_INDEX = 2'd3
	} status_e;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH,
		OP_SHIFT_DN,
		OP_SWAP_DN,
		OP_SHIFT_UP,
		OP_SWAP_UP
	} cell_op_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_e;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FILL_W-1:0]   fill_count;
		logic [WORD_W-1:0]   last_value;
	} out_item_t;

	// broadcast from control to every cell
	typedef struct packed {
		cell_op_e          op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] item;
		logic [WORD_W-1:0] pos_word;
		logic [WORD_W-1:0] last_word;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/bounded_array_list_engine_core.sv =====
// top level of the bounded array list engine: control and the row of entry cells
//
//  channel   signals              direction  handshake
//  command   start, busy, req     in         taken when start && !busy
//  result    done, rsp            out        one-cycle strobe, never stalled
//
// each command runs as capture, with the word at position read off the
// cell bus, an execute step in which every cell shifts or swaps in parallel, and
// a readback step that reads the new last entry back off the bus into the result.
// busy is high while a taken command is in its execute and readback steps.
// reset clears the count and control; entry contents stay undefined.
// the result cannot be held off: done marks it for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_list_engine_core
	import bal_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire in_item_t  req,
	output logic           done,
	output out_item_t      rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	state_e            state_q, state_d;
	in_item_t          req_q;
	logic [WORD_W-1:0] pos_word_q;
	logic [CW-1:0]     count_q, count_d;
	status_e           status_q, status_d;
	out_item_t         rsp_q;
	logic              done_q;
	cell_op_e          op_d;
	cell_ctrl_t        ctrl;
	logic [CW-1:0]     rd_idx;
	logic [WORD_W-1:0] bus;
	logic [WW-1:0]     pos_w, cnt_w;
	logic              accept;

	logic [WORD_W-1:0] word_w [CAPACITY];
	logic [WORD_W-1:0] tap_w  [CAPACITY];

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign pos_w  = WW'(req_q.position);
	assign cnt_w  = WW'(count_q);

	// status and cell operation for the captured command
	always_comb begin
		status_d = STS_OK;
		op_d     = OP_HOLD;
		count_d  = count_q;
		unique case (req_q.cmd)
			CMD_PUSH: begin
				if (count_q == CAP_CNT) status_d = STS_FULL;
				else begin
					op_d    = OP_PUSH;
					count_d = count_q + CW'(1);
				end
			end
			CMD_POP: begin
				if (count_q == '0) status_d = STS_EMPTY;
				else count_d = count_q - CW'(1);
			end
			CMD_REM_ORD, CMD_REM_SWAP: begin
				if (count_q == '0) status_d = STS_EMPTY;
				else if (pos_w >= cnt_w) status_d = STS_INDEX;
				else begin
					op_d    = (req_q.cmd == CMD_REM_ORD) ? OP_SHIFT_DN : OP_SWAP_DN;
					count_d = count_q - CW'(1);
				end
			end
			CMD_INS_ORD, CMD_INS_SWAP: begin
				if (pos_w >= cnt_w) status_d = STS_INDEX;
				else if (count_q == CAP_CNT) status_d = STS_FULL;
				else begin
					op_d    = (req_q.cmd == CMD_INS_ORD) ? OP_SHIFT_UP : OP_SWAP_UP;
					count_d = count_q + CW'(1);
				end
			end
			default: begin
				status_d = STS_OK;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_EXEC;
			ST_EXEC: state_d = ST_READ;
			ST_READ: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			status_q <= STS_OK;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_READ);
			if (state_q == ST_EXEC) begin
				count_q  <= count_d;
				status_q <= status_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req;
			pos_word_q <= bus;
		end
		if (state_q == ST_READ) begin
			rsp_q.status     <= status_q;
			rsp_q.fill_count <= FILL_W'(count_q);
			rsp_q.last_value <= (count_q == '0) ? '0 : bus;
		end
	end

	// outside readback, the result register holds the current last entry when count is nonzero
	assign ctrl.op        = (state_q == ST_EXEC) ? op_d : OP_HOLD;
	assign ctrl.pos       = req_q.position;
	assign ctrl.item      = req_q.item_value;
	assign ctrl.pos_word  = pos_word_q;
	assign ctrl.last_word = rsp_q.last_value;

	assign rd_idx = (state_q == ST_IDLE) ? CW'(req.position) : (count_q - CW'(1));

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_W-1:0] prev_w, next_w;
		if (i == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid_lo
			assign prev_w = word_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_hi
			assign next_w = word_w[i+1];
		end
		bal_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.rd_idx    (rd_idx),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (word_w[i]),
			.tap       (tap_w[i])
		);
	end

	always_comb begin
		bus = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			bus = bus | tap_w[k];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> done)
		else $error("result strobe missing after readback");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("fill count above capacity");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && count_q == '0) |-> (rsp.last_value == '0))
		else $error("empty list reports nonzero last value");

endmodule

`default_nettype wire

// ===== design/bal_cell.sv =====
// one entry cell of the list row
`timescale 1ns / 1ps
`default_nettype none

module bal_cell
	import bal_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int INDEX    = 0,
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  wire logic              clk,
	input  wire cell_ctrl_t        ctrl,
	input  wire logic [CW-1:0]     count,
	input  wire logic [CW-1:0]     rd_idx,
	input  wire logic [WORD_W-1:0] prev_word,
	input  wire logic [WORD_W-1:0] next_word,
	output logic      [WORD_W-1:0] word,
	output logic      [WORD_W-1:0] tap
);

	localparam logic [CW-1:0] ME      = CW'(INDEX);
	localparam logic [CW-1:0] ME_NEXT = CW'(INDEX + 1);

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] word_d;
	logic [CW-1:0]     pos;

	// position is known to be below count whenever the op is a shift or a swap
	assign pos = CW'(ctrl.pos);

	always_comb begin
		word_d = word_q;
		unique case (ctrl.op)
			OP_HOLD: begin
				word_d = word_q;
			end
			OP_PUSH: begin
				if (ME == count) word_d = ctrl.item;
			end
			OP_SHIFT_DN: begin
				if (ME >= pos && ME_NEXT < count) word_d = next_word;
			end
			OP_SWAP_DN: begin
				if (ME == pos) word_d = ctrl.last_word;
			end
			OP_SHIFT_UP: begin
				if (ME == pos) word_d = ctrl.item;
				else if (ME > pos && ME <= count) word_d = prev_word;
			end
			OP_SWAP_UP: begin
				if (ME == pos) word_d = ctrl.item;
				else if (ME == count) word_d = ctrl.pos_word;
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;
	assign tap  = (rd_idx == ME) ? word_q : '0;

endmodule

`default_nettype wire
